### design/url_percent_decoder_utf8_unit_macros.svh
// Assertion macros shared by the decoder RTL.
`ifndef URL_PERCENT_DECODER_UTF8_UNIT_MACROS_SVH
`define URL_PERCENT_DECODER_UTF8_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UPDU8_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("decoder assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define UPDU8_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("decoder assertion failed");

`endif

### design/updu8_pkg.sv
package updu8_pkg;

    localparam logic [15:0] PERCENT_CHAR = 16'h0025;
    localparam logic [15:0] SURR_MIN     = 16'hD800;
    localparam logic [15:0] HIGH_MAX     = 16'hDBFF;
    localparam logic [15:0] LOW_MIN      = 16'hDC00;
    localparam logic [15:0] SURR_MAX     = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE    = 21'h010000;
    localparam logic [20:0] CP_MAX       = 21'h10FFFF;
    localparam logic [20:0] TWO_BYTE_MIN = 21'h000080;
    localparam logic [20:0] THREE_MIN    = 21'h000800;
    localparam logic [5:0]  HIGH_PREFIX  = 6'b110110;
    localparam logic [5:0]  LOW_PREFIX   = 6'b110111;

    typedef enum logic [1:0] {
        PH_NONE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [15:0] unit;
        logic        unit_valid;
        logic        end_of_string;
        logic        failed;
    } t_result;

    // Bit 4 set marks a character that is not a hex digit.
    function automatic logic [4:0] hex_digit(input logic [15:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 16'h0030 && c <= 16'h0039) begin
            v = {1'b0, 4'(c - 16'h0030)};
        end else if (c >= 16'h0041 && c <= 16'h0046) begin
            v = {1'b0, 4'(c - 16'h0037)};
        end else if (c >= 16'h0061 && c <= 16'h0066) begin
            v = {1'b0, 4'(c - 16'h0057)};
        end
        return v;
    endfunction

endpackage

### design/url_percent_decoder_utf8_unit.sv
// Channel   | Direction | Payload                                   | Handshake
// s_axis    | in        | tdata[15:0] code_unit, tlast last         | tvalid/tready
// m_axis    | out       | tdata[15:0] unit, tuser valid/failed,     | tvalid/tready
//           |           | tlast end_of_string                       |
// Each input beat is decoded in the cycle it is accepted, and one beat per cycle is taken while tready is high.
// Its zero, one or two results enter a four-entry result queue and leave one per cycle while m_axis is ready.
// An input beat is taken while at most one result waits, so after a beat that yields two
// results the input is held until one of them leaves. Reset is synchronous and active low.
// A stall on the output side backs up into the queue and then into the input.
`include "url_percent_decoder_utf8_unit_macros.svh"
module url_percent_decoder_utf8_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // [15:0] code_unit
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,  // [15:0] unit
    output logic [1:0]  o_m_axis_tuser,  // [0] unit_valid, [1] failed
    output logic        o_m_axis_tlast
);
    import updu8_pkg::*;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_nib, n_nib;
    logic [1:0]  r_need, n_need;
    logic [20:0] r_part, n_part;
    logic [1:0]  r_cls, n_cls;
    logic [9:0]  r_held, n_held;
    logic        r_hv, n_hv;
    logic        r_err, n_err;

    t_result     r_fifo [0:3];
    logic [1:0]  r_wr, r_rd;
    logic [2:0]  r_count;

    logic        w_acc, w_pop;
    logic [15:0] w_c;
    logic [4:0]  w_hex;
    logic [7:0]  w_byte;
    logic [20:0] w_acc_val;
    logic [20:0] w_cp;
    logic [19:0] w_off;
    logic        w_emit, w_bad, w_fail;
    logic [1:0]  w_n, w_push;
    logic [15:0] w_b0, w_b1;
    t_result     w_e0, w_e1;

    assign w_c             = i_s_axis_tdata;
    assign o_s_axis_tready = (r_count[2:1] == 2'b00);
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = (r_count != 3'd0);
    assign w_pop           = o_m_axis_tvalid && i_m_axis_tready;
    assign o_m_axis_tdata  = r_fifo[r_rd].unit;
    assign o_m_axis_tuser  = {r_fifo[r_rd].failed, r_fifo[r_rd].unit_valid};
    assign o_m_axis_tlast  = r_fifo[r_rd].end_of_string;

    always_comb begin
        n_phase   = r_phase;
        n_nib     = r_nib;
        n_need    = r_need;
        n_part    = r_part;
        n_cls     = r_cls;
        n_held    = r_held;
        n_hv      = r_hv;
        n_err     = r_err;
        w_n       = 2'd0;
        w_b0      = 16'd0;
        w_b1      = 16'd0;
        w_emit    = 1'b0;
        w_bad     = 1'b0;
        w_cp      = 21'd0;
        w_off     = 20'd0;
        w_hex     = hex_digit(w_c);
        w_byte    = {r_nib, w_hex[3:0]};
        w_acc_val = {r_part[14:0], w_byte[5:0]};
        if (!r_err) begin
            if (r_hv) begin
                n_hv   = 1'b0;
                n_held = 10'd0;
                if (w_c >= LOW_MIN && w_c <= SURR_MAX) begin
                    w_b0 = {HIGH_PREFIX, r_held};
                    w_b1 = w_c;
                    w_n  = 2'd2;
                end else begin
                    n_err = 1'b1;
                end
            end else begin
                unique case (r_phase)
                    PH_HIGH: begin
                        if (w_hex[4]) begin
                            n_err = 1'b1;
                        end else begin
                            n_nib   = w_hex[3:0];
                            n_phase = PH_LOW;
                        end
                    end
                    PH_LOW: begin
                        if (w_hex[4]) begin
                            n_err = 1'b1;
                        end else begin
                            n_phase = PH_NONE;
                            n_nib   = 4'd0;
                            if (r_need == 2'd0) begin
                                priority if (!w_byte[7]) begin
                                    w_cp   = {13'd0, w_byte};
                                    w_emit = 1'b1;
                                end else if (w_byte[7:5] == 3'b110) begin
                                    n_need = 2'd1;
                                    n_cls  = 2'd1;
                                    n_part = {16'd0, w_byte[4:0]};
                                end else if (w_byte[7:4] == 4'b1110) begin
                                    n_need = 2'd2;
                                    n_cls  = 2'd2;
                                    n_part = {17'd0, w_byte[3:0]};
                                end else if (w_byte[7:3] == 5'b11110) begin
                                    n_need = 2'd3;
                                    n_cls  = 2'd3;
                                    n_part = {18'd0, w_byte[2:0]};
                                end else begin
                                    n_err = 1'b1;
                                end
                            end else if (w_byte[7:6] != 2'b10) begin
                                n_err = 1'b1;
                            end else begin
                                n_part = w_acc_val;
                                n_need = r_need - 2'd1;
                                if (r_need == 2'd1) begin
                                    unique case (r_cls)
                                        2'd1: w_bad = (w_acc_val < TWO_BYTE_MIN);
                                        2'd2: w_bad = (w_acc_val < THREE_MIN) ||
                                                      (w_acc_val >= {5'd0, SURR_MIN} &&
                                                       w_acc_val <= {5'd0, SURR_MAX});
                                        default: w_bad = (w_acc_val < SUPP_BASE) ||
                                                         (w_acc_val > CP_MAX);
                                    endcase
                                    n_part = 21'd0;
                                    n_cls  = 2'd0;
                                    if (w_bad) begin
                                        n_err = 1'b1;
                                    end else begin
                                        w_cp   = w_acc_val;
                                        w_emit = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_NONE;
                        if (w_c == PERCENT_CHAR) begin
                            n_phase = PH_HIGH;
                        end else if (r_need != 2'd0) begin
                            n_err = 1'b1;
                        end else if (w_c < SURR_MIN || w_c > SURR_MAX) begin
                            w_b0 = w_c;
                            w_n  = 2'd1;
                        end else if (w_c <= HIGH_MAX) begin
                            n_held = w_c[9:0];
                            n_hv   = 1'b1;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                endcase
            end
        end
        if (w_emit) begin
            if (w_cp[20:16] == 5'd0) begin
                w_b0 = w_cp[15:0];
                w_n  = 2'd1;
            end else begin
                w_off = 20'(w_cp - SUPP_BASE);
                w_b0  = {HIGH_PREFIX, w_off[19:10]};
                w_b1  = {LOW_PREFIX, w_off[9:0]};
                w_n   = 2'd2;
            end
        end
        if (n_err) begin
            w_n = 2'd0;
        end
        w_fail = n_err || (n_phase == PH_HIGH) || (n_phase == PH_LOW) || n_hv ||
                 (n_need != 2'd0);
        w_e0 = '{unit: w_b0, unit_valid: 1'b1, end_of_string: 1'b0, failed: 1'b0};
        w_e1 = '{unit: w_b1, unit_valid: 1'b1, end_of_string: 1'b0, failed: 1'b0};
        w_push = w_n;
        if (i_s_axis_tlast) begin
            if (w_fail || w_n == 2'd0) begin
                w_e0   = '{unit: 16'd0, unit_valid: 1'b0, end_of_string: 1'b1,
                           failed: w_fail};
                w_push = 2'd1;
            end else begin
                w_e0.end_of_string = (w_n == 2'd1);
                w_e1.end_of_string = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NONE;
            r_nib   <= 4'd0;
            r_need  <= 2'd0;
            r_part  <= 21'd0;
            r_cls   <= 2'd0;
            r_held  <= 10'd0;
            r_hv    <= 1'b0;
            r_err   <= 1'b0;
        end else if (w_acc) begin
            if (i_s_axis_tlast) begin
                r_phase <= PH_NONE;
                r_nib   <= 4'd0;
                r_need  <= 2'd0;
                r_part  <= 21'd0;
                r_cls   <= 2'd0;
                r_held  <= 10'd0;
                r_hv    <= 1'b0;
                r_err   <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_nib   <= n_nib;
                r_need  <= n_need;
                r_part  <= n_part;
                r_cls   <= n_cls;
                r_held  <= n_held;
                r_hv    <= n_hv;
                r_err   <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 2'd0;
            r_rd    <= 2'd0;
            r_count <= 3'd0;
        end else begin
            if (w_acc) begin
                r_wr <= r_wr + w_push;
            end
            if (w_pop) begin
                r_rd <= r_rd + 2'd1;
            end
            r_count <= r_count + (w_acc ? {1'b0, w_push} : 3'd0) - {2'd0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_push != 2'd0) begin
            r_fifo[r_wr] <= w_e0;
        end
        if (w_acc && w_push == 2'd2) begin
            r_fifo[r_wr + 2'd1] <= w_e1;
        end
    end

    `UPDU8_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= 3'd3)
    `UPDU8_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, w_acc && i_s_axis_tlast,
        r_phase == PH_NONE && !r_hv && !r_err && r_need == 2'd0)
    `UPDU8_ASSERT_NEXT(a_err_sticky, i_clk, i_rst_n, r_err && !(w_acc && i_s_axis_tlast),
        r_err)
    `UPDU8_ASSERT_SAME(a_ptr_count, i_clk, i_rst_n, 1'b1,
        r_count[1:0] == 2'(r_wr - r_rd) && (r_count != 3'd4))

endmodule
